FILE: rtl/vpv_pkg.sv
// Shared constants, register codes and divider lane type for the vertex projection block.
`default_nettype none
package vpv_pkg;

	localparam int CLIP_W  = 33;
	localparam int NUM_W   = 48;
	localparam int DEN_W   = 34;
	localparam int QUO_W   = 16;
	localparam int CMP_W   = NUM_W + 2;
	localparam int SIZE_W  = 13;
	localparam int ADDR_W  = 6;
	localparam int DATA_W  = 64;
	localparam int DIV_STAGES = QUO_W / 2;

	localparam logic [2:0] REG_ROW0   = 3'd0;
	localparam logic [2:0] REG_ROW1   = 3'd1;
	localparam logic [2:0] REG_ROW2   = 3'd2;
	localparam logic [2:0] REG_ROW3   = 3'd3;
	localparam logic [2:0] REG_WIDTH  = 3'd4;
	localparam logic [2:0] REG_HEIGHT = 3'd5;

	localparam logic [DATA_W-1:0] ROW0_RESET = 64'h0000_0000_0000_0100;
	localparam logic [DATA_W-1:0] ROW1_RESET = 64'h0000_0000_0100_0000;
	localparam logic [DATA_W-1:0] ROW2_RESET = 64'h0000_0100_0000_0000;
	localparam logic [DATA_W-1:0] ROW3_RESET = 64'h0100_0000_0000_0000;
	localparam logic [SIZE_W-1:0] WIDTH_RESET  = 13'd640;
	localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd480;

	localparam logic signed [15:0] SAT_MAX = 16'sh7FFF;
	localparam logic signed [15:0] SAT_MIN = 16'sh8000;

	typedef struct packed {
		logic [NUM_W-1:0] rem;
		logic [DEN_W-1:0] den;
		logic [QUO_W-1:0] quo;
		logic             neg;
		logic             ovf;
	} div_lane_t;

endpackage
`default_nettype wire

FILE: rtl/vertex_project_viewport.sv
// Vertex projection top level: matrix transform, perspective divide and viewport mapping.
//
// Points arrive on the input channel (in_valid, in_stall, point_x/y/z, signed Q8.8).
// Each transfer yields exactly one result on the output channel (screen_x, screen_y,
// depth in Q2.14 and valid_res, which is low when the clip w is zero).
// The matrix rows and viewport size are written through the APB port; writes are
// expected only while no point is in flight.
// From input transfer to output valid the pipeline has three stages for the products,
// row sums and numerators, one stage for magnitudes and overflow detection, eight
// stages of the restoring divider (two quotient bits per stage) and one output stage
// for sign and saturation. Throughput is one point per cycle unless the receiver
// stalls; the divider stages make up most of the latency.
// When the receiver stalls a valid result, the whole pipeline holds and in_stall
// rises in the same cycle; nothing is lost or repeated.
// Reset clears all stage valid bits and loads the identity matrix and a 640 by 480
// viewport.
`default_nettype none
module vertex_project_viewport (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_stall,
	input  wire  signed [15:0]               point_x,
	input  wire  signed [15:0]               point_y,
	input  wire  signed [15:0]               point_z,
	output logic                             out_valid,
	input  wire                              out_stall,
	output logic signed [15:0]               screen_x,
	output logic signed [15:0]               screen_y,
	output logic signed [15:0]               depth,
	output logic                             valid_res,
	input  wire                              psel,
	input  wire                              penable,
	input  wire                              pwrite,
	input  wire  [vpv_pkg::ADDR_W-1:0]       paddr,
	input  wire  [vpv_pkg::DATA_W-1:0]       pwdata,
	output logic [vpv_pkg::DATA_W-1:0]       prdata,
	output logic                             pready
);

	localparam int NS = vpv_pkg::DIV_STAGES;

	logic [vpv_pkg::DATA_W-1:0] row_q [4];
	logic [vpv_pkg::SIZE_W-1:0] width_q;
	logic [vpv_pkg::SIZE_W-1:0] height_q;
	logic [2:0]                 reg_idx;
	logic                       adv;

	assign pready  = 1'b1;
	assign reg_idx = paddr[5:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0] <= vpv_pkg::ROW0_RESET;
			row_q[1] <= vpv_pkg::ROW1_RESET;
			row_q[2] <= vpv_pkg::ROW2_RESET;
			row_q[3] <= vpv_pkg::ROW3_RESET;
			width_q  <= vpv_pkg::WIDTH_RESET;
			height_q <= vpv_pkg::HEIGHT_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				vpv_pkg::REG_ROW0:   row_q[0] <= pwdata;
				vpv_pkg::REG_ROW1:   row_q[1] <= pwdata;
				vpv_pkg::REG_ROW2:   row_q[2] <= pwdata;
				vpv_pkg::REG_ROW3:   row_q[3] <= pwdata;
				vpv_pkg::REG_WIDTH:  width_q  <= pwdata[vpv_pkg::SIZE_W-1:0];
				vpv_pkg::REG_HEIGHT: height_q <= pwdata[vpv_pkg::SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			vpv_pkg::REG_ROW0:   prdata = row_q[0];
			vpv_pkg::REG_ROW1:   prdata = row_q[1];
			vpv_pkg::REG_ROW2:   prdata = row_q[2];
			vpv_pkg::REG_ROW3:   prdata = row_q[3];
			vpv_pkg::REG_WIDTH:  prdata = {51'd0, width_q};
			vpv_pkg::REG_HEIGHT: prdata = {51'd0, height_q};
			default:             prdata = '0;
		endcase
	end

	// The pipeline moves as one whenever the output register is free or being taken.
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// Stage 1: coefficient products.
	logic               vld_s1;
	logic signed [31:0] prod_s1 [4][3];
	logic signed [15:0] wcoef_s1 [4];

	// Stage 2: clip coordinates.
	logic                                vld_s2;
	logic signed [vpv_pkg::CLIP_W-1:0]   clip_s2 [4];

	// Stage 3: numerators and denominators.
	logic                                vld_s3;
	logic                                zero_s3;
	logic signed [vpv_pkg::NUM_W-1:0]    num_s3 [3];
	logic signed [vpv_pkg::DEN_W-1:0]    den_s3 [3];
	logic signed [vpv_pkg::DEN_W:0]      sumx;
	logic signed [vpv_pkg::DEN_W:0]      sumy;

	// Divider stages; index 0 is loaded from stage 3.
	logic                      dv_vld  [NS+1];
	logic                      dv_zero [NS+1];
	vpv_pkg::div_lane_t        dv_s    [NS+1][3];
	vpv_pkg::div_lane_t        dv_next [NS][3];
	vpv_pkg::div_lane_t        dv_load [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			for (int k = 0; k <= NS; k++) dv_vld[k] <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			dv_vld[0] <= vld_s3;
			for (int k = 0; k < NS; k++) dv_vld[k+1] <= dv_vld[k];
			out_valid <= dv_vld[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 4; r++) begin
				prod_s1[r][0] <= $signed(row_q[r][15:0])  * point_x;
				prod_s1[r][1] <= $signed(row_q[r][31:16]) * point_y;
				prod_s1[r][2] <= $signed(row_q[r][47:32]) * point_z;
				wcoef_s1[r]   <= $signed(row_q[r][63:48]);
			end
			for (int r = 0; r < 4; r++) begin
				clip_s2[r] <= vpv_pkg::CLIP_W'(prod_s1[r][0])
					+ vpv_pkg::CLIP_W'(prod_s1[r][1])
					+ vpv_pkg::CLIP_W'(prod_s1[r][2])
					+ (vpv_pkg::CLIP_W'(wcoef_s1[r]) <<< 8);
			end
			num_s3[0] <= vpv_pkg::NUM_W'(sumx * $signed({1'b0, width_q}));
			num_s3[1] <= vpv_pkg::NUM_W'(sumy * $signed({1'b0, height_q}));
			num_s3[2] <= vpv_pkg::NUM_W'(clip_s2[2]) <<< 14;
			den_s3[0] <= vpv_pkg::DEN_W'(clip_s2[3]) <<< 1;
			den_s3[1] <= vpv_pkg::DEN_W'(clip_s2[3]) <<< 1;
			den_s3[2] <= vpv_pkg::DEN_W'(clip_s2[3]);
			zero_s3   <= (clip_s2[3] == '0);
			dv_s[0]    <= dv_load;
			dv_zero[0] <= zero_s3;
			for (int k = 0; k < NS; k++) begin
				dv_s[k+1]    <= dv_next[k];
				dv_zero[k+1] <= dv_zero[k];
			end
		end
	end

	always_comb begin
		sumx = (vpv_pkg::DEN_W+1)'(clip_s2[0]) + (vpv_pkg::DEN_W+1)'(clip_s2[3]);
		sumy = (vpv_pkg::DEN_W+1)'(clip_s2[3]) - (vpv_pkg::DEN_W+1)'(clip_s2[1]);
	end

	// Magnitudes, quotient sign and detection of quotients wider than sixteen bits.
	always_comb begin
		logic [vpv_pkg::NUM_W-1:0] nabs;
		logic [vpv_pkg::DEN_W-1:0] dabs;
		for (int l = 0; l < 3; l++) begin
			nabs = num_s3[l][vpv_pkg::NUM_W-1] ? vpv_pkg::NUM_W'(-num_s3[l])
			                                   : vpv_pkg::NUM_W'(num_s3[l]);
			dabs = den_s3[l][vpv_pkg::DEN_W-1] ? vpv_pkg::DEN_W'(-den_s3[l])
			                                   : vpv_pkg::DEN_W'(den_s3[l]);
			dv_load[l].rem = nabs;
			dv_load[l].den = dabs;
			dv_load[l].quo = '0;
			dv_load[l].neg = num_s3[l][vpv_pkg::NUM_W-1] ^ den_s3[l][vpv_pkg::DEN_W-1];
			dv_load[l].ovf = {2'b00, nabs} >= {dabs, 16'd0};
		end
	end

	// Restoring division, two quotient bits per stage, most significant first.
	always_comb begin
		logic [vpv_pkg::CMP_W-1:0] sh;
		vpv_pkg::div_lane_t        t;
		for (int k = 0; k < NS; k++) begin
			for (int l = 0; l < 3; l++) begin
				t = dv_s[k][l];
				for (int j = 0; j < 2; j++) begin
					sh = {16'd0, t.den} << (vpv_pkg::QUO_W - 1 - 2*k - j);
					if ({2'b00, t.rem} >= sh) begin
						t.rem = t.rem - sh[vpv_pkg::NUM_W-1:0];
						t.quo[vpv_pkg::QUO_W-1-2*k-j] = 1'b1;
					end
				end
				dv_next[k][l] = t;
			end
		end
	end

	// Sign and saturation.
	logic signed [15:0] res [3];

	always_comb begin
		vpv_pkg::div_lane_t t;
		for (int l = 0; l < 3; l++) begin
			t = dv_s[NS][l];
			if (dv_zero[NS]) begin
				res[l] = '0;
			end else if (!t.neg) begin
				res[l] = (t.ovf || t.quo[15]) ? vpv_pkg::SAT_MAX : $signed(t.quo);
			end else begin
				res[l] = (t.ovf || t.quo > 16'h8000) ? vpv_pkg::SAT_MIN : $signed(-t.quo);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			screen_x  <= res[0];
			screen_y  <= res[1];
			depth     <= res[2];
			valid_res <= !dv_zero[NS];
		end
	end

	a_zero_w_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !valid_res) |-> (screen_x == 0 && screen_y == 0 && depth == 0))
		else $error("undefined projection with nonzero fields");

	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a held output");

	a_hold_valids: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> ($stable(vld_s3) && $stable(dv_vld[NS]) && $stable(out_valid)))
		else $error("stage valid moved during stall");

endmodule
`default_nettype wire

FILE: test/tb_vertex_project_viewport.sv
// Self-checking testbench for the vertex projection block, with a built-in predictor.
`default_nettype none
module tb_vertex_project_viewport;

	typedef struct {
		logic signed [15:0] sx;
		logic signed [15:0] sy;
		logic signed [15:0] dz;
		logic               vr;
	} proj_t;

	typedef struct {
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic signed [15:0] pz;
		logic               known;
		proj_t              res;
	} vec_row_t;

	logic clk, arst_n;
	logic in_valid, out_stall;
	logic signed [15:0] point_x, point_y, point_z;
	logic in_stall, out_valid;
	logic signed [15:0] screen_x, screen_y, depth;
	logic valid_res;
	logic psel, penable, pwrite;
	logic [vpv_pkg::ADDR_W-1:0] paddr;
	logic [vpv_pkg::DATA_W-1:0] pwdata, prdata;
	logic pready;

	logic [63:0] mat_row [4];
	logic [12:0] vp_w, vp_h;
	proj_t       pending_proj[$];
	int          errors = 0;
	bit          calm = 0;
	bit          hold_long = 0;

	vertex_project_viewport uut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.out_valid(out_valid), .out_stall(out_stall), .screen_x(screen_x),
		.screen_y(screen_y), .depth(depth), .valid_res(valid_res),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#50000000;
		$display("tb_vertex_project_viewport: errors");
		$finish;
	end

	function automatic logic signed [15:0] clamp16(input logic signed [127:0] v);
		if (v > 32767)
			return 16'sh7FFF;
		if (v < -32768)
			return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic proj_t project(input logic signed [15:0] x, y, z);
		logic signed [127:0] p [4];
		logic signed [127:0] c [4];
		logic signed [15:0]  k;
		proj_t               r;
		p[0] = 128'(x); p[1] = 128'(y); p[2] = 128'(z); p[3] = 128'sd256;
		for (int i = 0; i < 4; i++) begin
			c[i] = '0;
			for (int j = 0; j < 4; j++) begin
				k = mat_row[i][16*j +: 16];
				c[i] += k * p[j];
			end
		end
		if (c[3] == 0) begin
			r = '{0, 0, 0, 1'b0};
			return r;
		end
		r.sx = clamp16(((c[0] + c[3]) * $signed({115'd0, vp_w})) / (2 * c[3]));
		r.sy = clamp16(((c[3] - c[1]) * $signed({115'd0, vp_h})) / (2 * c[3]));
		r.dz = clamp16((c[2] * 16384) / c[3]);
		r.vr = 1'b1;
		return r;
	endfunction

	task automatic report(input string what, input logic [15:0] got, want);
		$display("mismatch %s: got %h, want %h", what, got, want);
		errors++;
	endtask

	task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
		psel <= 1; pwrite <= 1; penable <= 0;
		paddr <= vpv_pkg::ADDR_W'({idx, 3'b000}); pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (idx)
			vpv_pkg::REG_ROW0, vpv_pkg::REG_ROW1, vpv_pkg::REG_ROW2,
			vpv_pkg::REG_ROW3: mat_row[idx[1:0]] = val;
			vpv_pkg::REG_WIDTH: vp_w = val[12:0];
			vpv_pkg::REG_HEIGHT: vp_h = val[12:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic settle();
		in_valid <= 0;
		while (pending_proj.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic send(input logic signed [15:0] x, y, z);
		int gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 0;
			gap = $urandom_range(1, 9);
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1; point_x <= x; point_y <= y; point_z <= z;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_proj.push_back(project(x, y, z));
	endtask

	// Receiver side: random stall bursts, plus one long hold-off on request.
	initial begin
		int n;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_long) begin
				out_stall <= 1;
				repeat (60) @(posedge clk);
				out_stall <= 0;
				hold_long = 0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				out_stall <= 1;
				n = $urandom_range(1, 9);
				repeat (n) @(posedge clk);
				out_stall <= 0;
			end
		end
	end

	always @(posedge clk) begin
		proj_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_proj.size() == 0) begin
				$display("unexpected transfer on the output");
				errors++;
			end else begin
				e = pending_proj.pop_front();
				if (screen_x !== e.sx) report("screen_x", screen_x, e.sx);
				if (screen_y !== e.sy) report("screen_y", screen_y, e.sy);
				if (depth !== e.dz) report("depth", depth, e.dz);
				if (valid_res !== e.vr) report("valid_res", 16'(valid_res), 16'(e.vr));
			end
		end
	end

	vec_row_t dir_rows [] = '{
		'{16'sh0000, 16'sh0000, 16'sh0000, 1'b1, '{16'sd320, 16'sd240, 16'sd0, 1'b1}},
		'{16'sh0100, 16'sh0000, 16'sh0000, 1'b1, '{16'sd640, 16'sd240, 16'sd0, 1'b1}},
		'{16'sh0000, 16'sh0100, 16'sh0000, 1'b1, '{16'sd320, 16'sd0, 16'sd0, 1'b1}},
		'{16'sh0000, 16'sh0000, 16'sh0100, 1'b1, '{16'sd320, 16'sd240, 16'sd16384, 1'b1}},
		'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0, '{0, 0, 0, 0}},
		'{16'sh8000, 16'sh8000, 16'sh8000, 1'b0, '{0, 0, 0, 0}},
		'{16'shFFFF, 16'sh0001, 16'sh8000, 1'b0, '{0, 0, 0, 0}},
		'{16'sh5555, 16'shAAAA, 16'sh00FF, 1'b0, '{0, 0, 0, 0}}
	};

	initial begin
		proj_t got;
		logic [63:0] r;
		arst_n = 0; in_valid = 0; point_x = 0; point_y = 0; point_z = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		mat_row[0] = vpv_pkg::ROW0_RESET; mat_row[1] = vpv_pkg::ROW1_RESET;
		mat_row[2] = vpv_pkg::ROW2_RESET; mat_row[3] = vpv_pkg::ROW3_RESET;
		vp_w = vpv_pkg::WIDTH_RESET; vp_h = vpv_pkg::HEIGHT_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			got = project(dir_rows[i].px, dir_rows[i].py, dir_rows[i].pz);
			if (dir_rows[i].known && (got.sx != dir_rows[i].res.sx ||
					got.sy != dir_rows[i].res.sy || got.dz != dir_rows[i].res.dz ||
					got.vr != dir_rows[i].res.vr))
				report("table row", 16'(i), 16'hFFFF);
			send(dir_rows[i].px, dir_rows[i].py, dir_rows[i].pz);
		end
		settle();

		// A zero w row gives an invalid result.
		reg_write(vpv_pkg::REG_ROW3, 64'h0);
		send(16'sh0100, 16'sh0200, 16'sh0300);
		settle();
		reg_write(vpv_pkg::REG_WIDTH, 64'd0);
		reg_write(vpv_pkg::REG_HEIGHT, 64'h1FFF);
		reg_write(vpv_pkg::REG_ROW3, 64'h0100_0000_0000_0000);
		send(16'sh0100, 16'shFF00, 16'sh0080);
		send(16'sh7FFF, 16'sh8000, 16'sh0001);
		settle();
		reg_write(vpv_pkg::REG_ROW0, 64'hFFFF_FFFF_FFFF_FFFF);
		reg_write(vpv_pkg::REG_ROW1, 64'h7FFF_7FFF_7FFF_7FFF);
		reg_write(vpv_pkg::REG_ROW2, 64'h8000_8000_8000_8000);
		reg_write(vpv_pkg::REG_ROW3, 64'h0001_0001_0001_0001);
		send(16'sh0001, 16'sh0001, 16'sh0001);
		send(16'sh8000, 16'sh7FFF, 16'sh0000);
		settle();

		for (int ph = 0; ph < 13; ph++) begin
			if (ph == 12)
				calm = 1;
			for (int i = 0; i < 4; i++) begin
				r = {$urandom, $urandom};
				if (ph % 3 == 0)
					r = {4{16'($signed($urandom_range(0, 1023)) - 512)}} & {$urandom, $urandom};
				reg_write(3'(i), r);
			end
			reg_write(vpv_pkg::REG_WIDTH,
				(ph == 1) ? 64'd4096 : 64'($urandom_range(0, 8191)));
			reg_write(vpv_pkg::REG_HEIGHT,
				(ph == 2) ? 64'd1 : 64'($urandom_range(0, 8191)));
			if (ph == 5)
				hold_long = 1;
			for (int i = 0; i < 100; i++)
				send(16'($urandom), 16'($urandom), 16'($urandom));
			settle();
		end

		if (errors == 0)
			$display("tb_vertex_project_viewport: clean");
		else
			$display("tb_vertex_project_viewport: errors");
		$finish;
	end
endmodule
`default_nettype wire
